// ----- rtl/core/dbnd_pkg.sv -----
// Shared types and constants for the disparity band nearest-depth core.
`timescale 1ns / 1ps
package dbnd_pkg;

   localparam int DispW  = 16;
   localparam int ColW   = 12;
   localparam int FocW   = 16;
   localparam int BaseW  = 20;
   localparam int WidthW = 13;
   localparam int DepthW = 20;
   localparam int LatW   = 21;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 20;
   localparam int DivNumW  = 37;
   localparam int DivDenW  = 25;

   localparam logic [CsrIdxW-1:0] RegFocal   = 2'd0;
   localparam logic [CsrIdxW-1:0] RegBase    = 2'd1;
   localparam logic [CsrIdxW-1:0] RegMinDisp = 2'd2;
   localparam logic [CsrIdxW-1:0] RegWidth   = 2'd3;

   localparam logic [DepthW-1:0] DepthMax = '1;

   typedef struct packed {
      logic signed [DispW-1:0] disparity_q4;
      logic [ColW-1:0]         column;
      logic                    column_end;
   } req_type;

   typedef struct packed {
      logic signed [LatW-1:0] lateral_mm;
      logic [DepthW-1:0]      depth_mm;
      logic [ColW-1:0]        point_column;
   } rsp_type;

   // queued item with its classification
   typedef struct packed {
      logic [DispW-2:0] disp_mag;
      logic [ColW-1:0]  column;
      logic             column_end;
      logic             pix_ok;
   } item_type;

endpackage

// ----- rtl/core/dbnd_front.sv -----
// Front end: accepts pixel items, classifies them and queues them.
`timescale 1ns / 1ps
module dbnd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dbnd_pkg::req_type             req_data,
   input  logic signed [dbnd_pkg::DispW-1:0] min_disp,
   output logic                          q_valid,
   input  logic                          q_pop,
   output dbnd_pkg::item_type            q_item
);
   import dbnd_pkg::*;

   item_type  slot_ff [2];
   item_type  new_item;
   logic      rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;

   // classify: positive and not below the minimum
   always_comb begin
      new_item.disp_mag   = req_data.disparity_q4[DispW-2:0];
      new_item.column     = req_data.column;
      new_item.column_end = req_data.column_end;
      new_item.pix_ok     = (req_data.disparity_q4 > 0) && (req_data.disparity_q4 >= min_disp);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   // advance queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end
endmodule

// ----- rtl/core/dbnd_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dbnd_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [dbnd_pkg::DivNumW-1:0]     dividend,
   input  logic [dbnd_pkg::DivDenW-1:0]     divisor,
   output logic                             done,
   output logic [dbnd_pkg::DivNumW-1:0]     quotient
);
   import dbnd_pkg::*;

   logic [DivNumW-1:0] quo_ff, quo_in;
   logic [DivDenW:0]   rem_ff, rem_in, rem_sh;
   logic [DivDenW-1:0] den_ff, den_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic               fits;

   assign rem_sh = {rem_ff[DivDenW-1:0], quo_ff[DivNumW-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = 6'(DivNumW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_in = {quo_ff[DivNumW-2:0], fits};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- rtl/core/dbnd_back.sv -----
// Back end: depth per pixel, nearest per column, offset and result register.
`timescale 1ns / 1ps
module dbnd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  dbnd_pkg::item_type                q_item,
   input  logic [dbnd_pkg::FocW-1:0]         focal,
   input  logic [dbnd_pkg::BaseW-1:0]        baseline,
   input  logic [dbnd_pkg::WidthW-1:0]       img_width,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dbnd_pkg::rsp_type                 rsp_data
);
   import dbnd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DPREP, S_DDIV, S_END, S_LPREP, S_LDIV, S_OUT
   } state_type;

   state_type            state_ff;
   logic [35:0]          prod_ff;
   logic [DivDenW-1:0]   den_ff;
   logic [ColW-1:0]      col_ff;
   logic                 end_ff, neg_ff, has_ff;
   logic [DepthW-1:0]    best_ff;
   logic signed [LatW-1:0] lat_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 div_start, div_done;
   logic [DivNumW-1:0]   div_num, div_q;
   logic [DivDenW-1:0]   div_den;
   logic [DepthW-1:0]    depth_sat;
   logic signed [13:0]   off;
   logic [12:0]          mag;
   logic                 q_big_pos, q_big_neg;

   dbnd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign div_start = (state_ff == S_DPREP) || (state_ff == S_LPREP && focal != '0);
   always_comb begin
      if (state_ff == S_DPREP) begin
         div_num = {1'b0, prod_ff} + DivNumW'(den_ff >> 1);
         div_den = den_ff;
      end else begin
         div_num = {1'b0, prod_ff[32:0], 3'b000} + DivNumW'(focal >> 1);
         div_den = DivDenW'(focal);
      end
   end

   assign depth_sat = (div_q[DivNumW-1:DepthW] != '0) ? DepthMax : div_q[DepthW-1:0];
   assign q_big_pos = (div_q[DivNumW-1:DepthW] != '0);
   assign q_big_neg = (div_q[DivNumW-1:LatW] != '0) ||
                      (div_q[DepthW] && (div_q[DepthW-1:0] != '0));

   // signed offset from the optical centre, doubled
   assign off = $signed({1'b0, col_ff, 1'b0}) - $signed({1'b0, img_width});
   assign mag = off[13] ? 13'(-off) : 13'(off);

   assign q_pop     = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         has_ff       <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result once taken, unless a new one is loaded this cycle
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  prod_ff  <= 36'(focal * baseline);
                  den_ff   <= DivDenW'(q_item.disp_mag * 10'd1000);
                  col_ff   <= q_item.column;
                  end_ff   <= q_item.column_end;
                  state_ff <= q_item.pix_ok ? S_DPREP : S_END;
               end
            end
            S_DPREP: state_ff <= S_DDIV;
            S_DDIV: begin
               if (div_done) begin
                  // keep strictly nearer depth
                  if (!has_ff || depth_sat < best_ff) begin
                     best_ff <= depth_sat;
                     has_ff  <= 1'b1;
                  end
                  state_ff <= S_END;
               end
            end
            S_END: begin
               if (!end_ff) begin
                  state_ff <= S_IDLE;
               end else if (!has_ff) begin
                  best_ff  <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  neg_ff   <= off[13];
                  prod_ff  <= 36'(mag * best_ff);
                  state_ff <= S_LPREP;
               end
            end
            S_LPREP: begin
               if (focal == '0) begin
                  lat_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_LDIV;
               end
            end
            S_LDIV: begin
               if (div_done) begin
                  if (neg_ff) begin
                     lat_ff <= q_big_neg ? LatW'(21'sh100000) : -$signed(div_q[LatW-1:0]);
                  end else begin
                     lat_ff <= q_big_pos ? LatW'(21'sh0FFFFF) : $signed(div_q[LatW-1:0]);
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // hold until the result register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.lateral_mm   <= lat_ff;
                  rsp_ff.depth_mm     <= best_ff;
                  rsp_ff.point_column <= col_ff;
                  rsp_valid_ff        <= 1'b1;
                  best_ff             <= '0;
                  has_ff              <= 1'b0;
                  state_ff            <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/core/disparity_band_nearest_depth_core.sv -----
// A valid pixel holds the back end for a depth division on the 37-step serial divider; an
// invalid one skips it. A column end with a point adds the offset division, skipped when
// focal is zero. Both divisions share one serial divider, so the back end takes a new item
// only once it is through with the last, and it waits for rsp_ready to free the result
// register. Reset (synchronous, active high) restores register defaults and clears the
// column state. A two-item queue lets the input side run ahead of the divider.
`timescale 1ns / 1ps
module disparity_band_nearest_depth_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  dbnd_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dbnd_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dbnd_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [dbnd_pkg::CsrDataW-1:0]     csr_wdata
);
   import dbnd_pkg::*;

   logic [FocW-1:0]          focal_ff;
   logic [BaseW-1:0]         base_ff;
   logic signed [DispW-1:0]  min_disp_ff;
   logic [WidthW-1:0]        width_ff;
   logic                     q_valid, q_pop;
   item_type                 q_item;

   assign csr_ready = 1'b1;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff    <= 16'd8000;
         base_ff     <= 20'd100000;
         min_disp_ff <= '0;
         width_ff    <= 13'd640;
      end else if (csr_valid) begin
         unique case (csr_index)
            RegFocal:   focal_ff    <= csr_wdata[FocW-1:0];
            RegBase:    base_ff     <= csr_wdata[BaseW-1:0];
            RegMinDisp: min_disp_ff <= $signed(csr_wdata[DispW-1:0]);
            RegWidth:   width_ff    <= csr_wdata[WidthW-1:0];
            default: ;
         endcase
      end
   end

   dbnd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .min_disp  (min_disp_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   dbnd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .focal     (focal_ff),
      .baseline  (base_ff),
      .img_width (width_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
